/* hdl/dtwsc_pkg.sv */
// Shared types and constants of the slope-constrained backward DTW block.
// Used by the row buffer, the cell unit, the top level and the checker.
// Depends on nothing.
package dtwsc_pkg;

	localparam int MAX_LEN_DEF = 256;
	localparam int LEN_W       = 9;
	localparam int DIST_W      = 16;
	localparam int COST_W      = 32;
	localparam int SUM_W       = 34;
	localparam int POS_W       = 8;
	localparam int CODE_W      = 3;
	localparam int CFG_IDX_W   = 1;

	localparam logic [COST_W-1:0] COST_MAX = '1;

	typedef enum logic [CODE_W-1:0] {
		STEP_GOAL    = 3'd0,
		STEP_21      = 3'd1,
		STEP_11      = 3'd2,
		STEP_12      = 3'd3,
		STEP_NOWHERE = 3'd4
	} step_code_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEN_A = 1'b0,
		REG_LEN_B = 1'b1
	} cfg_reg_t;

	// Which successor steps stay inside the grid for the current cell.
	typedef struct packed {
		logic goal;
		logic s21;
		logic s11;
		logic s12;
	} cand_ok_t;

	// Row buffer controls for one cycle.
	typedef struct packed {
		logic wr_en;
		logic rotate;
	} rb_ctrl_t;

endpackage

/* hdl/dtwsc_rowbuf.sv */
// Row buffers: three rotating cost rows and one distance row, each MAX_LEN deep.
// Reads are registered and addressed ahead from the scan counters' next position.
// Depends on dtwsc_pkg.
module dtwsc_rowbuf #(
	parameter int MAX_LEN = dtwsc_pkg::MAX_LEN_DEF,
	parameter int IDX_W   = $clog2(MAX_LEN)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  dtwsc_pkg::rb_ctrl_t             ctrl,
	input  logic [IDX_W-1:0]                wr_col,
	input  logic [dtwsc_pkg::COST_W-1:0]    wr_cost,
	input  logic [dtwsc_pkg::DIST_W-1:0]    wr_dist,
	input  logic [IDX_W-1:0]                rd_col,
	output logic [dtwsc_pkg::COST_W-1:0]    cost_next,
	output logic [dtwsc_pkg::COST_W-1:0]    cost_after,
	output logic [dtwsc_pkg::DIST_W-1:0]    dist_next
);

	// ptr_q names the bank that takes the current row; the bank after it
	// (mod 3) holds row a+2 and the one before it holds row a+1.
	logic [1:0]                   ptr_q;
	logic [dtwsc_pkg::COST_W-1:0] rd_cost_q [3];
	logic [dtwsc_pkg::DIST_W-1:0] dist_mem [MAX_LEN];
	logic [IDX_W-1:0]             rd_col_p1;

	assign rd_col_p1 = rd_col + IDX_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= 2'd0;
		end else if (ctrl.rotate) begin
			ptr_q <= (ptr_q == 2'd2) ? 2'd0 : ptr_q + 2'd1;
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_bank
		logic [dtwsc_pkg::COST_W-1:0] cost_mem [MAX_LEN];

		always_ff @(posedge clk) begin
			if (ctrl.wr_en && ptr_q == 2'(k)) begin
				cost_mem[wr_col] <= wr_cost;
			end
			rd_cost_q[k] <= cost_mem[rd_col_p1];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			dist_mem[wr_col] <= wr_dist;
		end
		dist_next <= dist_mem[rd_col];
	end

	always_comb begin
		case (ptr_q)
			2'd0: begin
				cost_next  = rd_cost_q[2];
				cost_after = rd_cost_q[1];
			end
			2'd1: begin
				cost_next  = rd_cost_q[0];
				cost_after = rd_cost_q[2];
			end
			2'd2: begin
				cost_next  = rd_cost_q[1];
				cost_after = rd_cost_q[0];
			end
			default: begin
				cost_next  = rd_cost_q[0];
				cost_after = rd_cost_q[0];
			end
		endcase
	end

endmodule

/* hdl/dtwsc_cell.sv */
// Cell unit: takes the goal cell's own distance, else forms the three weighted
// candidate sums and picks the cheapest in-range one, saturating to all ones. Depends on dtwsc_pkg.
module dtwsc_cell (
	input  dtwsc_pkg::cand_ok_t              ok,
	input  logic [dtwsc_pkg::DIST_W-1:0]     d,
	input  logic [dtwsc_pkg::DIST_W-1:0]     d_below,
	input  logic [dtwsc_pkg::DIST_W-1:0]     d_prev,
	input  logic [dtwsc_pkg::COST_W-1:0]     c_after1,
	input  logic [dtwsc_pkg::COST_W-1:0]     c_next1,
	input  logic [dtwsc_pkg::COST_W-1:0]     c_next2,
	output logic [dtwsc_pkg::COST_W-1:0]     cost,
	output dtwsc_pkg::step_code_t            code
);

	localparam int SW = dtwsc_pkg::SUM_W;

	logic [SW-1:0] sum21;
	logic [SW-1:0] sum11;
	logic [SW-1:0] sum12;

	assign sum21 = SW'(c_after1) + (SW'(d_below) << 1) + SW'(d);
	assign sum11 = SW'(c_next1) + (SW'(d) << 1);
	assign sum12 = SW'(c_next2) + (SW'(d_prev) << 1) + SW'(d);

	// Best starts at all ones, so a strict compare also rejects saturated sums.
	// Ties keep the earlier step.
	always_comb begin
		logic [SW-1:0] best;
		best = SW'(dtwsc_pkg::COST_MAX);
		code = dtwsc_pkg::STEP_NOWHERE;
		if (ok.goal) begin
			best = SW'(d);
			code = dtwsc_pkg::STEP_GOAL;
		end else begin
			if (ok.s21 && sum21 < best) begin
				best = sum21;
				code = dtwsc_pkg::STEP_21;
			end
			if (ok.s11 && sum11 < best) begin
				best = sum11;
				code = dtwsc_pkg::STEP_11;
			end
			if (ok.s12 && sum12 < best) begin
				best = sum12;
				code = dtwsc_pkg::STEP_12;
			end
		end
		cost = best[dtwsc_pkg::COST_W-1:0];
	end

endmodule

/* hdl/dtw_slope_constrained_backward.sv */
// Backward DTW with the symmetric slope constraint: top level with scan
// counters, length registers and the result register.
// Depends on dtwsc_pkg, dtwsc_rowbuf and dtwsc_cell.

// The block takes one local distance per clock, in backward raster order
// (row len_a-1 down to 0, each row from column len_b-1 down to 0), and gives
// one result per distance: the cell's cost to the goal corner, its step code
// and its position. A result appears in the cycle after its distance is
// accepted, and a new distance is accepted in every cycle while the result
// register is free or being emptied. The rate is set by the cell unit, which
// does all three candidate sums and the selection combinationally, fed by
// row buffers (three cost rows, one distance row, MAX_LEN words each) that
// are read ahead from the next scan position. Writing either length
// register restarts the scan at the goal corner; after cell (0,0) the scan
// wraps to the goal corner of a new grid of the same size. Lengths of zero
// act as one, and lengths above MAX_LEN act as MAX_LEN.
module dtw_slope_constrained_backward #(
	parameter int MAX_LEN = dtwsc_pkg::MAX_LEN_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dtwsc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dtwsc_pkg::LEN_W-1:0]         cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [dtwsc_pkg::DIST_W-1:0]        local_dist,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [dtwsc_pkg::COST_W-1:0]        cost_to_goal,
	output logic [dtwsc_pkg::CODE_W-1:0]        step_code,
	output logic [dtwsc_pkg::POS_W-1:0]         pos_a,
	output logic [dtwsc_pkg::POS_W-1:0]         pos_b,
	output logic                                last
);

	localparam int IDX_W = $clog2(MAX_LEN);
	localparam int EW    = IDX_W + 2;
	localparam int CW    = (IDX_W + 1 > dtwsc_pkg::LEN_W) ? IDX_W + 1 : dtwsc_pkg::LEN_W;

	logic [IDX_W-1:0]             la_m1_q;
	logic [IDX_W-1:0]             lb_m1_q;
	logic [IDX_W-1:0]             ta_q;
	logic [IDX_W-1:0]             tb_q;
	logic [IDX_W-1:0]             la_m1_d;
	logic [IDX_W-1:0]             lb_m1_d;
	logic [IDX_W-1:0]             ta_d;
	logic [IDX_W-1:0]             tb_d;
	logic [IDX_W-1:0]             cfg_m1;
	logic [dtwsc_pkg::DIST_W-1:0] prev_d_q;
	logic [dtwsc_pkg::COST_W-1:0] cost_next2_q;
	logic                         out_valid_q;
	logic                         cfg_we;
	logic                         in_acc;
	logic                         row_end;

	logic [dtwsc_pkg::COST_W-1:0] cost_next;
	logic [dtwsc_pkg::COST_W-1:0] cost_after;
	logic [dtwsc_pkg::DIST_W-1:0] dist_next;
	logic [dtwsc_pkg::COST_W-1:0] cell_cost;
	dtwsc_pkg::step_code_t        cell_code;
	dtwsc_pkg::cand_ok_t          ok;
	dtwsc_pkg::rb_ctrl_t          rb_ctrl;

	logic [EW-1:0] ta_e;
	logic [EW-1:0] tb_e;
	logic [EW-1:0] la_e;
	logic [EW-1:0] lb_e;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid;
	assign in_ready  = !out_valid_q || out_ready;
	assign in_acc    = in_valid && in_ready;
	assign row_end   = (tb_q == '0);

	// Effective length minus one of the value being written.
	always_comb begin
		if (cfg_data == '0) begin
			cfg_m1 = '0;
		end else if (CW'(cfg_data) > CW'(MAX_LEN)) begin
			cfg_m1 = IDX_W'(MAX_LEN - 1);
		end else begin
			cfg_m1 = IDX_W'(cfg_data - dtwsc_pkg::LEN_W'(1));
		end
	end

	// Next lengths and scan position; the row buffers are addressed from the scan position.
	always_comb begin
		la_m1_d = la_m1_q;
		lb_m1_d = lb_m1_q;
		ta_d    = ta_q;
		tb_d    = tb_q;
		if (cfg_we) begin
			case (cfg_index)
				dtwsc_pkg::REG_LEN_A: la_m1_d = cfg_m1;
				dtwsc_pkg::REG_LEN_B: lb_m1_d = cfg_m1;
				default: ;
			endcase
			ta_d = la_m1_d;
			tb_d = lb_m1_d;
		end else if (in_acc) begin
			if (row_end) begin
				tb_d = lb_m1_q;
				ta_d = (ta_q == '0) ? la_m1_q : ta_q - IDX_W'(1);
			end else begin
				tb_d = tb_q - IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			la_m1_q  <= '0;
			lb_m1_q  <= '0;
			ta_q     <= '0;
			tb_q     <= '0;
			prev_d_q <= '0;
		end else begin
			la_m1_q <= la_m1_d;
			lb_m1_q <= lb_m1_d;
			ta_q    <= ta_d;
			tb_q    <= tb_d;
			if (cfg_we || (in_acc && row_end)) begin
				prev_d_q <= '0;
			end else if (in_acc) begin
				prev_d_q <= local_dist;
			end
		end
	end

	// Cost of row a+1 two columns on is what the previous cell read one column on.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cost_next2_q <= cost_next;
		end
	end

	assign ta_e = EW'(ta_q);
	assign tb_e = EW'(tb_q);
	assign la_e = EW'(la_m1_q);
	assign lb_e = EW'(lb_m1_q);

	always_comb begin
		ok.goal = (ta_q == la_m1_q) && (tb_q == lb_m1_q);
		ok.s21  = (ta_e + EW'(2) <= la_e) && (tb_e + EW'(1) <= lb_e);
		ok.s11  = (ta_e + EW'(1) <= la_e) && (tb_e + EW'(1) <= lb_e);
		ok.s12  = (ta_e + EW'(1) <= la_e) && (tb_e + EW'(2) <= lb_e);
	end

	assign rb_ctrl.wr_en  = in_acc;
	assign rb_ctrl.rotate = in_acc && row_end && !cfg_we;

	dtwsc_rowbuf #(
		.MAX_LEN (MAX_LEN),
		.IDX_W   (IDX_W)
	) u_rowbuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (rb_ctrl),
		.wr_col     (tb_q),
		.wr_cost    (cell_cost),
		.wr_dist    (local_dist),
		.rd_col     (tb_d),
		.cost_next  (cost_next),
		.cost_after (cost_after),
		.dist_next  (dist_next)
	);

	dtwsc_cell u_cell (
		.ok       (ok),
		.d        (local_dist),
		.d_below  (dist_next),
		.d_prev   (prev_d_q),
		.c_after1 (cost_after),
		.c_next1  (cost_next),
		.c_next2  (cost_next2_q),
		.cost     (cell_cost),
		.code     (cell_code)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cost_to_goal <= cell_cost;
			step_code    <= cell_code;
			pos_a        <= dtwsc_pkg::POS_W'(ta_q);
			pos_b        <= dtwsc_pkg::POS_W'(tb_q);
			last         <= (ta_q == '0) && (tb_q == '0);
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* hdl/dtwsc_checker.sv */
// Port-level checker for the backward DTW block, bound to its top level.
// Depends on dtwsc_pkg.
module dtwsc_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [dtwsc_pkg::COST_W-1:0]        cost_to_goal,
	input logic [dtwsc_pkg::CODE_W-1:0]        step_code,
	input logic [dtwsc_pkg::POS_W-1:0]         pos_a,
	input logic [dtwsc_pkg::POS_W-1:0]         pos_b,
	input logic                                last
);

	// Every accepted word yields a result on the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted word produced no result");

	// A stalled result holds its payload.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cost_to_goal)
			&& $stable(step_code) && $stable(pos_a) && $stable(pos_b))
		else $error("stalled result changed");

	// The goal cell costs only its own distance, so its cost fits in a distance's width.
	a_goal_cost: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && step_code == dtwsc_pkg::STEP_GOAL |-> cost_to_goal[31:16] == '0)
		else $error("goal cost wider than a distance");

	// An unreachable cell reports saturated cost.
	a_nowhere_cost: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && step_code == dtwsc_pkg::STEP_NOWHERE |-> cost_to_goal == dtwsc_pkg::COST_MAX)
		else $error("unreachable cell without saturated cost");

	// The last flag marks cell (0,0) only.
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> pos_a == '0 && pos_b == '0)
		else $error("last flag away from the origin cell");

endmodule

bind dtw_slope_constrained_backward dtwsc_checker u_dtwsc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.cost_to_goal (cost_to_goal),
	.step_code    (step_code),
	.pos_a        (pos_a),
	.pos_b        (pos_b),
	.last         (last)
);

/* bench/tb_top.sv */
// Self-checking bench for the slope-constrained backward DTW block.
// Predicts every cell result locally and compares it with the block output.
// Depends on dtwsc_pkg and dtw_slope_constrained_backward.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int GRID_MAX     = dtwsc_pkg::MAX_LEN_DEF;
	localparam int GRID_IDX_W   = $clog2(GRID_MAX);
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int RANDOM_ITEMS = 400;
	localparam int REPORT_MAX   = 10;

	typedef struct packed {
		logic [dtwsc_pkg::COST_W-1:0] cost;
		dtwsc_pkg::step_code_t        code;
		logic [dtwsc_pkg::POS_W-1:0]  row_idx;
		logic [dtwsc_pkg::POS_W-1:0]  col_idx;
		logic                         is_last;
	} cell_result_t;

	logic                            clk        = 1'b0;
	logic                            arst_n     = 1'b0;
	logic                            cfg_valid  = 1'b0;
	logic                            cfg_ready;
	logic [dtwsc_pkg::CFG_IDX_W-1:0] cfg_index  = dtwsc_pkg::REG_LEN_A;
	logic [dtwsc_pkg::LEN_W-1:0]     cfg_data   = '0;
	logic                            in_valid   = 1'b0;
	logic                            in_ready;
	logic [dtwsc_pkg::DIST_W-1:0]    local_dist = '0;
	logic                            out_valid;
	logic                            out_ready  = 1'b0;
	logic [dtwsc_pkg::COST_W-1:0]    cost_to_goal;
	logic [dtwsc_pkg::CODE_W-1:0]    step_code;
	logic [dtwsc_pkg::POS_W-1:0]     pos_a;
	logic [dtwsc_pkg::POS_W-1:0]     pos_b;
	logic                            last;

	// Stimulus and scoreboard state.
	logic [dtwsc_pkg::DIST_W-1:0] dist_pending[$];
	cell_result_t      due_cells[$];
	int                items_pushed  = 0;
	int                items_taken   = 0;
	int                fail_count    = 0;
	int                cycle_count   = 0;
	int                send_gap_pct  = 0;
	int                stall_pct     = 0;
	logic              hold_go       = 1'b0;
	logic              hold_done     = 1'b0;
	int                hold_left     = 0;

	// Local copy of the lengths, the row buffers and the scan position.
	logic [dtwsc_pkg::LEN_W-1:0]  len_a_q;
	logic [dtwsc_pkg::LEN_W-1:0]  len_b_q;
	logic [dtwsc_pkg::COST_W-1:0] cost_next[GRID_MAX];
	logic [dtwsc_pkg::COST_W-1:0] cost_after[GRID_MAX];
	logic [dtwsc_pkg::COST_W-1:0] cost_here[GRID_MAX];
	logic [dtwsc_pkg::DIST_W-1:0] dist_next[GRID_MAX];
	logic [dtwsc_pkg::DIST_W-1:0] dist_prev;
	int unsigned                  row_pos;
	int unsigned                  col_pos;

	dtw_slope_constrained_backward u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.local_dist   (local_dist),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.cost_to_goal (cost_to_goal),
		.step_code    (step_code),
		.pos_a        (pos_a),
		.pos_b        (pos_b),
		.last         (last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int unsigned grid_len(logic [dtwsc_pkg::LEN_W-1:0] v);
		if (v == '0) return 32'd1;
		if (32'(v) > GRID_MAX) return GRID_MAX;
		return 32'(v);
	endfunction

	function automatic void restart_scan();
		row_pos   = grid_len(len_a_q) - 32'd1;
		col_pos   = grid_len(len_b_q) - 32'd1;
		dist_prev = '0;
	endfunction

	function automatic void note_failure(string msg);
		fail_count++;
		if (fail_count <= REPORT_MAX) $display("%s", msg);
	endfunction

	// A candidate at or above all ones is saturated and never taken.
	function automatic void keep_cheaper(input logic [dtwsc_pkg::SUM_W-1:0] sum,
			input dtwsc_pkg::step_code_t c,
			inout logic [dtwsc_pkg::COST_W-1:0] best, inout dtwsc_pkg::step_code_t code);
		if (sum < {2'b00, dtwsc_pkg::COST_MAX} && sum < {2'b00, best}) begin
			best = sum[dtwsc_pkg::COST_W-1:0];
			code = c;
		end
	endfunction

	// Works out the result of one cell and advances the backward raster scan.
	function automatic void predict_cell(logic [dtwsc_pkg::DIST_W-1:0] d);
		int unsigned                  la;
		int unsigned                  lb;
		int unsigned                  ta;
		int unsigned                  tb;
		logic [GRID_IDX_W-1:0]        ix0;
		logic [GRID_IDX_W-1:0]        ix1;
		logic [GRID_IDX_W-1:0]        ix2;
		logic [dtwsc_pkg::DIST_W-1:0] d_below;
		logic [dtwsc_pkg::SUM_W-1:0]  sum;
		logic [dtwsc_pkg::COST_W-1:0] best;
		dtwsc_pkg::step_code_t        code;
		cell_result_t                 res;
		la = grid_len(len_a_q);
		lb = grid_len(len_b_q);
		ta = (row_pos >= la) ? la - 32'd1 : row_pos;
		tb = (col_pos >= lb) ? lb - 32'd1 : col_pos;
		ix0 = tb[GRID_IDX_W-1:0];
		ix1 = GRID_IDX_W'(tb + 32'd1);
		ix2 = GRID_IDX_W'(tb + 32'd2);
		d_below = dist_next[ix0];
		best = dtwsc_pkg::COST_MAX;
		code = dtwsc_pkg::STEP_NOWHERE;
		if (ta == la - 1 && tb == lb - 1) begin
			best = {16'b0, d};
			code = dtwsc_pkg::STEP_GOAL;
		end else begin
			if (ta + 2 < la && tb + 1 < lb) begin
				sum = {2'b00, cost_after[ix1]} + {17'b0, d_below, 1'b0} + {18'b0, d};
				keep_cheaper(sum, dtwsc_pkg::STEP_21, best, code);
			end
			if (ta + 1 < la && tb + 1 < lb) begin
				sum = {2'b00, cost_next[ix1]} + {17'b0, d, 1'b0};
				keep_cheaper(sum, dtwsc_pkg::STEP_11, best, code);
			end
			if (ta + 1 < la && tb + 2 < lb) begin
				sum = {2'b00, cost_next[ix2]} + {17'b0, dist_prev, 1'b0} + {18'b0, d};
				keep_cheaper(sum, dtwsc_pkg::STEP_12, best, code);
			end
		end
		res.cost    = best;
		res.code    = code;
		res.row_idx = ta[dtwsc_pkg::POS_W-1:0];
		res.col_idx = tb[dtwsc_pkg::POS_W-1:0];
		res.is_last = (ta == 0 && tb == 0);
		due_cells.push_back(res);

		cost_here[ix0] = best;
		dist_next[ix0] = d;
		dist_prev      = d;
		if (tb == 0) begin
			cost_after = cost_next;
			cost_next  = cost_here;
			col_pos    = lb - 32'd1;
			row_pos    = (ta == 0) ? la - 32'd1 : ta - 32'd1;
			dist_prev  = '0;
		end else begin
			col_pos = tb - 32'd1;
			row_pos = ta;
		end
	endfunction

	// Input driver: predicts each accepted word and takes the next distance word from the pending queue.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				predict_cell(local_dist);
				items_taken++;
			end
			if (!in_valid || in_ready) begin
				if (dist_pending.size() != 0 && int'($urandom_range(99)) >= send_gap_pct) begin
					in_valid   <= 1'b1;
					local_dist <= dist_pending.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, started once by the sequencer.
	always @(posedge clk) begin
		if (hold_go && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Output monitor: checks each accepted result word against the oldest prediction and drives out_ready.
	always @(posedge clk) begin : rx_side
		cell_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_cells.size() == 0) begin
					note_failure($sformatf({"unexpected result: cost=%08h code=%0d ",
						"pos=(%0d,%0d) last=%0b"},
						cost_to_goal, step_code, pos_a, pos_b, last));
				end else begin
					want = due_cells.pop_front();
					if (cost_to_goal !== want.cost || step_code !== want.code ||
							pos_a !== want.row_idx || pos_b !== want.col_idx ||
							last !== want.is_last)
						note_failure($sformatf({"mismatch: expected cost=%08h code=%0d ",
							"pos=(%0d,%0d) last=%0b, got cost=%08h code=%0d ",
							"pos=(%0d,%0d) last=%0b"},
							want.cost, want.code, want.row_idx, want.col_idx, want.is_last,
							cost_to_goal, step_code, pos_a, pos_b, last));
				end
			end
			if (hold_left != 0 || (hold_go && !hold_done))
				out_ready <= 1'b0;
			else
				out_ready <= (int'($urandom_range(99)) >= stall_pct);
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic write_len(dtwsc_pkg::cfg_reg_t idx, logic [dtwsc_pkg::LEN_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		if (idx == dtwsc_pkg::REG_LEN_A) len_a_q = val;
		else len_b_q = val;
		restart_scan();
	endtask

	task automatic set_lengths(logic [dtwsc_pkg::LEN_W-1:0] a,
			logic [dtwsc_pkg::LEN_W-1:0] b);
		write_len(dtwsc_pkg::REG_LEN_A, a);
		write_len(dtwsc_pkg::REG_LEN_B, b);
	endtask

	// Idle mix: none, sender gaps, receiver stalls, or both.
	task automatic set_idling(int mode);
		case (mode % 4)
			0: begin send_gap_pct <= 0;  stall_pct <= 0;  end
			1: begin send_gap_pct <= 60; stall_pct <= 0;  end
			2: begin send_gap_pct <= 0;  stall_pct <= 60; end
			default: begin send_gap_pct <= 35; stall_pct <= 35; end
		endcase
	endtask

	task automatic offer(logic [dtwsc_pkg::DIST_W-1:0] v);
		dist_pending.push_back(v);
		items_pushed++;
	endtask

	// Small values make ties between the steps common.
	function automatic logic [dtwsc_pkg::DIST_W-1:0] random_dist();
		int unsigned r;
		r = $urandom_range(9);
		if (r < 4) return dtwsc_pkg::DIST_W'($urandom_range(3));
		if (r == 4) return ($urandom_range(1) != 0) ? '1 : '0;
		return dtwsc_pkg::DIST_W'($urandom);
	endfunction

	task automatic offer_random(int n);
		repeat (n) offer(random_dist());
	endtask

	// Waits until every word is taken and every result is back, then lets the
	// result register settle before the next register write.
	task automatic drain();
		do @(posedge clk); while (items_taken != items_pushed || due_cells.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [dtwsc_pkg::LEN_W-1:0] wide_len();
		case ($urandom_range(3))
			0: return '0;
			1: return dtwsc_pkg::LEN_W'(GRID_MAX);
			2: return '1;
			default: return dtwsc_pkg::LEN_W'($urandom_range(GRID_MAX + 1, 510));
		endcase
	endfunction

	initial begin : sequencer
		logic [dtwsc_pkg::LEN_W-1:0] a;
		logic [dtwsc_pkg::LEN_W-1:0] b;
		int                          n;
		int                          cells;
		int                          phase_no;
		int                          random_items;
		len_a_q    = 9'd1;
		len_b_q    = 9'd1;
		cost_next  = '{default: '0};
		cost_after = '{default: '0};
		cost_here  = '{default: '0};
		dist_next  = '{default: '0};
		restart_scan();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Lengths after reset: a single-cell grid that wraps on every word.
		offer(16'h0000); offer(16'hFFFF);
		drain();
		// A zero row length acts as one: only the goal is reachable.
		set_lengths(9'd0, 9'd3);
		offer(16'hFFFF); offer(16'h0000); offer(16'h0007);
		drain();
		// Equal distances give tied candidates.
		set_lengths(9'd3, 9'd3);
		repeat (9) offer(16'h0002);
		drain();
		set_lengths(9'd4, 9'd2);
		offer(16'hFFFF); offer(16'h0000); offer(16'hFFFF); offer(16'hFFFF);
		offer(16'h0000); offer(16'h0000); offer(16'hFFFF); offer(16'h0001);
		drain();

		// Receiver holds off while words keep coming, so the input backs up.
		set_lengths(9'd4, 9'd6);
		offer_random(60);
		hold_go <= 1'b1;
		drain();

		// Full-width rows with the row length clamped to the maximum.
		set_lengths('1, dtwsc_pkg::LEN_W'(GRID_MAX));
		set_idling(3);
		offer_random(270);
		drain();

		phase_no = 0;
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			case ($urandom_range(9))
				0: begin
					a = wide_len();
					b = dtwsc_pkg::LEN_W'($urandom_range(1, 4));
					n = int'($urandom_range(10, 40));
				end
				1: begin
					a = dtwsc_pkg::LEN_W'($urandom_range(1, 4));
					b = wide_len();
					n = int'($urandom_range(10, 40));
				end
				default: begin
					a = dtwsc_pkg::LEN_W'($urandom_range(0, 8));
					b = dtwsc_pkg::LEN_W'($urandom_range(0, 8));
					cells = int'(grid_len(a) * grid_len(b));
					n = ($urandom_range(3) == 0) ? int'($urandom_range(1, cells))
						: cells * int'($urandom_range(1, 3));
				end
			endcase
			if ($urandom_range(1) != 0) begin
				write_len(dtwsc_pkg::REG_LEN_B, b);
				write_len(dtwsc_pkg::REG_LEN_A, a);
			end else begin
				set_lengths(a, b);
			end
			set_idling(phase_no);
			offer_random(n);
			drain();
			random_items += n;
			phase_no++;
		end

		repeat (8) @(posedge clk);
		if (due_cells.size() != 0)
			note_failure($sformatf("%0d results never arrived", due_cells.size()));
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* sim.f */
hdl/dtwsc_pkg.sv
hdl/dtwsc_rowbuf.sv
hdl/dtwsc_cell.sv
hdl/dtw_slope_constrained_backward.sv
hdl/dtwsc_checker.sv
bench/tb_top.sv
